// ===== sv/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and microcode encodings for the block buffer cache.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  localparam int BUFFERS    = 4;
  localparam int BUF_W      = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam int BLOCK_BITS = 24;
  localparam int SECTOR_W   = 25;
  localparam int PC_W       = 5;

  // operation codes
  localparam logic [2:0] OP_GET    = 3'd0;
  localparam logic [2:0] OP_ASSIGN = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_EMPTY  = 3'd3;
  localparam logic [2:0] OP_SAVE   = 3'd4;
  localparam logic [2:0] OP_FLUSH  = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_FINAL = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_FILL  = 2'd3;

  typedef struct packed {
    logic [2:0]            operation;
    logic [BLOCK_BITS-1:0] block_id;
    logic                  read_ok;
    logic                  write_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                drive;
    logic [1:0]          buffer;
    logic [SECTOR_W-1:0] sector;
    logic                ok;
    logic                last;
  } out_item_t;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_SEARCH,
    ACT_WB_VICTIM,
    ACT_READ,
    ACT_FILL,
    ACT_FINAL_FETCH,
    ACT_FINAL_HIT,
    ACT_FINAL_FLAG,
    ACT_MARK_DIRTY,
    ACT_START_SCAN,
    ACT_WB_SCAN,
    ACT_NEXT_I,
    ACT_EMPTY,
    ACT_SET_FLAG,
    ACT_CLR_FLAG
  } act_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_HIT,
    C_NO_VICTIM,
    C_NO_WB,
    C_FILL,
    C_NO_DRIVE,
    C_CLEAN_I,
    C_MORE_I,
    C_NOT_FLUSH
  } cond_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    act_t act;
    logic fire;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic hit;
    logic no_victim;
    logic no_wb;
    logic fill;
    logic no_drive;
    logic clean_i;
    logic more_i;
    logic not_flush;
    logic out_free;
  } status_t;

  // actions that may place a request in the output register
  function automatic logic act_emits(input act_t a);
    case (a)
      ACT_WB_VICTIM, ACT_READ, ACT_FILL, ACT_FINAL_FETCH,
      ACT_FINAL_HIT, ACT_FINAL_FLAG, ACT_WB_SCAN: act_emits = 1'b1;
      default:                                    act_emits = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/bbc_sequencer.sv =====
// ----------------------------------------------------------------------------
// bbc_sequencer
// Step counter and microcode table; issues one datapath action per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [2:0]       operation,
  input  wire bbc_pkg::status_t st,
  output bbc_pkg::ctrl_t        ctrl,
  output logic                  running
);
  import bbc_pkg::*;

  // program entry points
  localparam logic [PC_W-1:0] PC_FETCH  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_HIT    = PC_W'(9);
  localparam logic [PC_W-1:0] PC_FAIL   = PC_W'(10);
  localparam logic [PC_W-1:0] PC_UPDATE = PC_W'(12);
  localparam logic [PC_W-1:0] PC_EMPTY  = PC_W'(14);
  localparam logic [PC_W-1:0] PC_SAVE   = PC_W'(15);
  localparam logic [PC_W-1:0] PC_SCAN   = PC_W'(16);
  localparam logic [PC_W-1:0] PC_NEXT   = PC_W'(18);
  localparam logic [PC_W-1:0] PC_EMPTY2 = PC_W'(20);
  localparam logic [PC_W-1:0] PC_FINAL2 = PC_W'(21);

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] a);
    unique case (a)
      5'd0:    ucode_rom = '{ACT_SEARCH,      C_HIT,       PC_HIT,    1'b0};
      5'd1:    ucode_rom = '{ACT_NONE,        C_NO_VICTIM, PC_FAIL,   1'b0};
      5'd2:    ucode_rom = '{ACT_NONE,        C_NO_WB,     PC_W'(4),  1'b0};
      5'd3:    ucode_rom = '{ACT_WB_VICTIM,   C_NEVER,     PC_FETCH,  1'b0};
      5'd4:    ucode_rom = '{ACT_NONE,        C_FILL,      PC_W'(7),  1'b0};
      5'd5:    ucode_rom = '{ACT_CLR_FLAG,    C_NO_DRIVE,  PC_W'(8),  1'b0};
      5'd6:    ucode_rom = '{ACT_READ,        C_ALWAYS,    PC_W'(8),  1'b0};
      5'd7:    ucode_rom = '{ACT_FILL,        C_NEVER,     PC_FETCH,  1'b0};
      5'd8:    ucode_rom = '{ACT_FINAL_FETCH, C_NEVER,     PC_FETCH,  1'b1};
      5'd9:    ucode_rom = '{ACT_FINAL_HIT,   C_NEVER,     PC_FETCH,  1'b1};
      5'd10:   ucode_rom = '{ACT_CLR_FLAG,    C_NEVER,     PC_FETCH,  1'b0};
      5'd11:   ucode_rom = '{ACT_FINAL_FLAG,  C_NEVER,     PC_FETCH,  1'b1};
      5'd12:   ucode_rom = '{ACT_MARK_DIRTY,  C_NEVER,     PC_FETCH,  1'b0};
      5'd13:   ucode_rom = '{ACT_FINAL_FLAG,  C_NEVER,     PC_FETCH,  1'b1};
      5'd14:   ucode_rom = '{ACT_SET_FLAG,    C_ALWAYS,    PC_EMPTY2, 1'b0};
      5'd15:   ucode_rom = '{ACT_START_SCAN,  C_NEVER,     PC_FETCH,  1'b0};
      5'd16:   ucode_rom = '{ACT_NONE,        C_CLEAN_I,   PC_NEXT,   1'b0};
      5'd17:   ucode_rom = '{ACT_WB_SCAN,     C_NEVER,     PC_FETCH,  1'b0};
      5'd18:   ucode_rom = '{ACT_NEXT_I,      C_MORE_I,    PC_SCAN,   1'b0};
      5'd19:   ucode_rom = '{ACT_NONE,        C_NOT_FLUSH, PC_FINAL2, 1'b0};
      5'd20:   ucode_rom = '{ACT_EMPTY,       C_NEVER,     PC_FETCH,  1'b0};
      5'd21:   ucode_rom = '{ACT_FINAL_FLAG,  C_NEVER,     PC_FETCH,  1'b1};
      default: ucode_rom = '{ACT_NONE,        C_NEVER,     PC_FETCH,  1'b1};
    endcase
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] op);
    unique case (op)
      OP_GET, OP_ASSIGN: entry_pc = PC_FETCH;
      OP_UPDATE:         entry_pc = PC_UPDATE;
      OP_EMPTY:          entry_pc = PC_EMPTY;
      OP_SAVE, OP_FLUSH: entry_pc = PC_SAVE;
      default:           entry_pc = PC_FAIL;
    endcase
  endfunction

  logic [PC_W-1:0] pc;
  ucode_t          word;
  logic            taken;
  logic            advance;

  assign word = ucode_rom(pc);

  always_comb begin
    case (word.cond)
      C_ALWAYS:    taken = 1'b1;
      C_HIT:       taken = st.hit;
      C_NO_VICTIM: taken = st.no_victim;
      C_NO_WB:     taken = st.no_wb;
      C_FILL:      taken = st.fill;
      C_NO_DRIVE:  taken = st.no_drive;
      C_CLEAN_I:   taken = st.clean_i;
      C_MORE_I:    taken = st.more_i;
      C_NOT_FLUSH: taken = st.not_flush;
      default:     taken = 1'b0;
    endcase
  end

  // a step that may emit waits for room in the output register
  assign advance   = running && (!act_emits(word.act) || st.out_free);
  assign ctrl.act  = running ? word.act : ACT_NONE;
  assign ctrl.fire = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= PC_FETCH;
    end else if (!running) begin
      if (start) begin
        running <= 1'b1;
        pc      <= entry_pc(operation);
      end
    end else if (advance) begin
      if (word.done) begin
        running <= 1'b0;
      end else if (taken) begin
        pc <= word.target;
      end else begin
        pc <= pc + PC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bbc_datapath.sv =====
// ----------------------------------------------------------------------------
// bbc_datapath
// Buffer tags and marks, search logic, scan index and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bbc_pkg::in_item_t item,
  input  wire logic [1:0]        drive_select,
  input  wire bbc_pkg::ctrl_t    ctrl,
  output bbc_pkg::status_t       st,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output bbc_pkg::out_item_t     out_data
);
  import bbc_pkg::*;

  logic [BLOCK_BITS-1:0] tag [BUFFERS];
  logic [BUFFERS-1:0]    valid;
  logic [BUFFERS-1:0]    current;
  logic [BUFFERS-1:0]    dirty;

  logic [BUF_W-1:0] victim;
  logic             victim_found;
  logic [BUF_W-1:0] idx;
  logic             flag;

  logic             hit_any;
  logic [BUF_W-1:0] hit_sel;
  logic             vic_any;
  logic [BUF_W-1:0] vic_sel;
  logic             cur_any;
  logic [BUF_W-1:0] cur_sel;
  logic             no_drive;
  logic             out_free;
  logic             emit;
  out_item_t        res;

  assign no_drive = drive_select[1];
  assign out_free = !out_valid || !out_stall;

  // priority searches: lowest index wins
  always_comb begin
    hit_any = 1'b0;
    hit_sel = '0;
    vic_any = 1'b0;
    vic_sel = '0;
    cur_any = 1'b0;
    cur_sel = '0;
    for (int k = BUFFERS - 1; k >= 0; k--) begin
      if (valid[k] && tag[k] == item.block_id) begin
        hit_any = 1'b1;
        hit_sel = BUF_W'(k);
      end
      if (current[k]) begin
        cur_any = 1'b1;
        cur_sel = BUF_W'(k);
      end
    end
    for (int k = BUFFERS - 1; k >= 0; k--) begin
      if (!current[k]) begin
        vic_any = 1'b1;
        vic_sel = BUF_W'(k);
      end
    end
    // an empty buffer beats a non-current one
    for (int k = BUFFERS - 1; k >= 0; k--) begin
      if (!valid[k]) begin
        vic_any = 1'b1;
        vic_sel = BUF_W'(k);
      end
    end
  end

  assign st.hit       = hit_any;
  assign st.no_victim = !victim_found;
  assign st.no_wb     = !(valid[victim] && dirty[victim]) || no_drive;
  assign st.fill      = (item.operation == OP_ASSIGN);
  assign st.no_drive  = no_drive;
  assign st.clean_i   = !dirty[idx];
  assign st.more_i    = (idx != BUF_W'(BUFFERS - 1));
  assign st.not_flush = (item.operation != OP_FLUSH);
  assign st.out_free  = out_free;

  // result formed by the current action
  always_comb begin
    res  = '0;
    emit = 1'b0;
    if (ctrl.fire) begin
      case (ctrl.act)
        ACT_WB_VICTIM: begin
          emit       = 1'b1;
          res.kind   = KIND_WRITE;
          res.drive  = drive_select[0];
          res.buffer = 2'(victim);
          res.sector = {tag[victim], 1'b0};
        end
        ACT_WB_SCAN: begin
          emit       = !no_drive;
          res.kind   = KIND_WRITE;
          res.drive  = drive_select[0];
          res.buffer = 2'(idx);
          res.sector = {tag[idx], 1'b0};
        end
        ACT_READ: begin
          emit       = 1'b1;
          res.kind   = KIND_READ;
          res.drive  = drive_select[0];
          res.buffer = 2'(victim);
          res.sector = {item.block_id, 1'b0};
        end
        ACT_FILL: begin
          emit       = 1'b1;
          res.kind   = KIND_FILL;
          res.buffer = 2'(victim);
        end
        ACT_FINAL_FETCH: begin
          emit       = 1'b1;
          res.kind   = KIND_FINAL;
          res.buffer = flag ? 2'(victim) : 2'd0;
          res.ok     = flag;
          res.last   = 1'b1;
        end
        ACT_FINAL_HIT: begin
          emit       = 1'b1;
          res.kind   = KIND_FINAL;
          res.buffer = 2'(hit_sel);
          res.ok     = 1'b1;
          res.last   = 1'b1;
        end
        ACT_FINAL_FLAG: begin
          emit       = 1'b1;
          res.kind   = KIND_FINAL;
          res.ok     = flag;
          res.last   = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      current      <= '0;
      dirty        <= '0;
      victim       <= '0;
      victim_found <= 1'b0;
      idx          <= '0;
      flag         <= 1'b0;
      for (int k = 0; k < BUFFERS; k++) begin
        tag[k] <= '0;
      end
    end else if (ctrl.fire) begin
      case (ctrl.act)
        ACT_SEARCH: begin
          victim       <= vic_sel;
          victim_found <= vic_any;
          current      <= '0;
        end
        ACT_WB_VICTIM: begin
          if (item.write_ok) begin
            dirty[victim] <= 1'b0;
          end
        end
        ACT_READ: begin
          flag <= item.read_ok;
        end
        ACT_FILL: begin
          flag <= 1'b1;
        end
        ACT_FINAL_FETCH: begin
          if (flag) begin
            tag[victim]     <= item.block_id;
            valid[victim]   <= 1'b1;
            current[victim] <= 1'b1;
            dirty[victim]   <= 1'b0;
          end
        end
        ACT_FINAL_HIT: begin
          current[hit_sel] <= 1'b1;
        end
        ACT_MARK_DIRTY: begin
          flag <= cur_any;
          if (cur_any) begin
            dirty[cur_sel] <= 1'b1;
          end
        end
        ACT_START_SCAN: begin
          flag <= 1'b1;
          idx  <= '0;
        end
        ACT_WB_SCAN: begin
          if (no_drive || !item.write_ok) begin
            flag <= 1'b0;
          end else begin
            dirty[idx] <= 1'b0;
          end
        end
        ACT_NEXT_I: begin
          idx <= idx + BUF_W'(1);
        end
        ACT_EMPTY: begin
          valid   <= '0;
          current <= '0;
          dirty   <= '0;
          for (int k = 0; k < BUFFERS; k++) begin
            tag[k] <= '0;
          end
        end
        ACT_SET_FLAG: begin
          flag <= 1'b1;
        end
        ACT_CLR_FLAG: begin
          flag <= 1'b0;
        end
        default: begin
          flag <= flag;
        end
      endcase
    end
  end

  a_current_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(current))
    else $error("more than one buffer marked current");

  a_current_valid: assert property (@(posedge clk) disable iff (rst)
    (current & ~valid) == '0)
    else $error("current mark on an empty buffer");

  a_dirty_valid: assert property (@(posedge clk) disable iff (rst)
    (dirty & ~valid) == '0)
    else $error("dirty mark on an empty buffer");

endmodule

`default_nettype wire

// ===== sv/block_buffer_cache_manager_core.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_manager_core
// Fully associative write-back cache manager for four block buffers.
// ----------------------------------------------------------------------------
// An item is registered on acceptance and then run by a microcoded sequencer,
// one table step per cycle, each step that may emit waiting while the output
// register holds an untaken request. A program runs 2 steps for update, 3 for
// empty-all, 2 to 8 for get and assign (hit 2, no evictable buffer 4, miss 6
// to 8 with a write-back adding 1), and 3 + 2 * BUFFERS (+ dirty buffers, + 1
// for flush) for save-all and flush; no new item is taken until the program of
// the last one has finished.
// in_stall is high from acceptance until the final request has been loaded
// into the output register. There is no clearing pass after reset.
`default_nettype none

module block_buffer_cache_manager_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bbc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bbc_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_data
);
  import bbc_pkg::*;

  in_item_t   item;
  logic [1:0] drive_select;
  logic       running;
  logic       start;
  ctrl_t      ctrl;
  status_t    st;

  assign in_stall  = running;
  assign start     = in_valid && !running;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (start) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_select <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      drive_select <= cfg_data;
    end
  end

  bbc_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (in_data.operation),
    .st        (st),
    .ctrl      (ctrl),
    .running   (running)
  );

  bbc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .drive_select (drive_select),
    .ctrl         (ctrl),
    .st           (st),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire
